[rtl/srt_pkg.sv]
// Shared types and constants for the sensor reading table.
// Entry record layout, status and opcode codes, the default table size and limits.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srt_pkg;

  localparam int TableEntriesDefault = 16;

  localparam logic [7:0] MISSED_LIMIT = 8'd250;
  localparam logic [6:0] FRACT_MAX    = 7'd99;

  typedef enum logic [2:0] {
    OP_SCAN_TICK = 3'd0,
    OP_READING   = 3'd1,
    OP_OVR_SET   = 3'd2,
    OP_OVR_CLEAR = 3'd3,
    OP_READ      = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_NEW_ENTRY = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_UNSET     = 3'd4
  } status_t;

  // one table entry as kept in the entry memory
  typedef struct packed {
    logic [63:0] key;
    logic        valid;
    logic        forced;
    logic        sign;
    logic [11:0] magnitude;
    logic [6:0]  hundredths;
    logic [7:0]  missed;
  } entry_t;

endpackage

`default_nettype wire

[rtl/srt_entry_mem.sv]
// Entry storage for the sensor reading table: one write port, one read port,
// registered read data. Uses srt_pkg::entry_t for the word layout.
`timescale 1ns / 1ps
`default_nettype none

module srt_entry_mem #(
  parameter int DEPTH = srt_pkg::TableEntriesDefault,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire srt_pkg::entry_t   wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output srt_pkg::entry_t        rdata
);

  srt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/sensor_reading_table_core.sv]
// Top level of the sensor reading table: handshake, sequencer and output
// register. Depends on srt_pkg and srt_entry_mem.
//
// A table of TABLE_ENTRIES sensor entries keyed by 64-bit ID. Lookups, scan
// ticks and allocations walk the entry memory one entry per cycle through a
// single 64-bit key comparator, so a scan tick, reading, override set or
// override clear walks all entries in S_SCAN before S_FINISH; a read entry
// goes through S_READ, undefined opcodes straight to S_FINISH. One item is in
// flight at a time; in_ready is high while the sequencer is idle, and a
// finished result waits in the output register while the next item is
// taken. The used bits are cleared at reset, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module sensor_reading_table_core #(
  parameter int TABLE_ENTRIES = srt_pkg::TableEntriesDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         opcode,
  input  wire logic [63:0]        sensor_id,
  input  wire logic [3:0]         entry_select,
  input  wire logic signed [11:0] value_whole,
  input  wire logic [6:0]         value_fract,
  input  wire logic               fract_present,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              status,
  output logic [3:0]              entry_index,
  output logic                    is_set,
  output logic                    is_override,
  output logic                    is_negative,
  output logic [11:0]             whole_magnitude,
  output logic [6:0]              fraction,
  output logic [7:0]              missed_scans,
  output logic                    rescan_request
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_READ   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;

  // latched item
  srt_pkg::opcode_t op_q;
  logic [63:0]      id_q;
  logic [3:0]       sel_q;
  logic [11:0]      whole_q;
  logic [6:0]       fract_q;
  logic             fpres_q;

  // scan bookkeeping
  logic [CW-1:0]    cnt;
  logic             pend;
  logic [AW-1:0]    pidx;
  logic             found;
  logic [AW-1:0]    hit_idx;
  srt_pkg::entry_t  hit_rec;
  logic             free_found;
  logic [AW-1:0]    free_idx;

  logic [TABLE_ENTRIES-1:0] used;

  // memory ports
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  srt_pkg::entry_t  mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  srt_pkg::entry_t  rd_data;

  srt_entry_mem #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  logic [AW-1:0] sel_idx;
  logic          sel_ok;
  logic          scan_issue;
  logic          tick_we;
  srt_pkg::entry_t tick_rec;

  assign sel_idx    = AW'(sel_q);
  assign sel_ok     = 32'(sel_q) < TABLE_ENTRIES;
  assign scan_issue = (state == S_SCAN) && (32'(cnt) < TABLE_ENTRIES);
  assign in_ready   = (state == S_IDLE);

  // scan tick ages the entry whose data just came back
  always_comb begin
    tick_rec        = rd_data;
    tick_rec.missed = rd_data.missed + 8'd1;
    tick_we = (state == S_SCAN) && pend && (op_q == srt_pkg::OP_SCAN_TICK) &&
              used[pidx] && (rd_data.missed < srt_pkg::MISSED_LIMIT);
  end

  // finishing step: new record, write back and result fields
  logic             fin_go;
  logic             fin_we;
  logic             fin_alloc;
  logic             fin_report;
  logic             fin_rescan;
  logic [AW-1:0]    fin_idx;
  srt_pkg::entry_t  fin_rec;
  srt_pkg::status_t fin_status;
  logic [3:0]       fin_index;
  logic [11:0]      neg_whole;

  assign fin_go    = (state == S_FINISH) && (!out_valid || out_ready);
  assign neg_whole = (~whole_q) + 12'd1;

  always_comb begin
    fin_rec    = hit_rec;
    fin_idx    = hit_idx;
    fin_status = srt_pkg::ST_DONE;
    fin_we     = 1'b0;
    fin_alloc  = 1'b0;
    fin_report = 1'b0;
    fin_rescan = 1'b0;
    fin_index  = 4'd0;
    unique case (op_q)
      srt_pkg::OP_READING: begin
        if (!found) begin
          if (free_found) begin
            fin_idx     = free_idx;
            fin_rec     = '0;
            fin_rec.key = id_q;
            fin_alloc   = 1'b1;
            fin_status  = srt_pkg::ST_NEW_ENTRY;
          end else begin
            fin_status  = srt_pkg::ST_FULL;
          end
        end
        if (found || free_found) begin
          fin_rec.valid = 1'b1;
          if (!fin_rec.forced) begin
            fin_rec.sign       = whole_q[11];
            fin_rec.magnitude  = whole_q[11] ? neg_whole : whole_q;
            fin_rec.hundredths = fract_q;
            fin_rec.missed     = 8'd0;
          end
          fin_we     = 1'b1;
          fin_report = 1'b1;
        end
      end
      srt_pkg::OP_OVR_SET: begin
        if (found) begin
          fin_rec.valid     = 1'b1;
          fin_rec.forced    = 1'b1;
          fin_rec.sign      = whole_q[11];
          fin_rec.magnitude = whole_q[11] ? neg_whole : whole_q;
          if (fpres_q) begin
            fin_rec.hundredths = fract_q;
          end
          fin_we     = 1'b1;
          fin_report = 1'b1;
        end else begin
          fin_status = srt_pkg::ST_NOT_FOUND;
        end
      end
      srt_pkg::OP_OVR_CLEAR: begin
        if (found) begin
          fin_rec.valid  = 1'b0;
          fin_rec.forced = 1'b0;
          fin_we     = 1'b1;
          fin_report = 1'b1;
          fin_rescan = 1'b1;
        end else begin
          fin_status = srt_pkg::ST_NOT_FOUND;
        end
      end
      srt_pkg::OP_READ: begin
        if (sel_ok && used[sel_idx] && rd_data.valid) begin
          fin_rec    = rd_data;
          fin_idx    = sel_idx;
          fin_report = 1'b1;
        end else begin
          fin_status = srt_pkg::ST_UNSET;
          fin_index  = sel_q;
        end
      end
      default: begin
      end
    endcase
    if (fin_report) begin
      fin_index = 4'(fin_idx);
    end
  end

  // memory port steering
  always_comb begin
    mem_re    = scan_issue || (state == S_READ);
    mem_raddr = (state == S_READ) ? sel_idx : cnt[AW-1:0];
    if (tick_we) begin
      mem_we    = 1'b1;
      mem_waddr = pidx;
      mem_wdata = tick_rec;
    end else begin
      mem_we    = fin_go && fin_we;
      mem_waddr = fin_idx;
      mem_wdata = fin_rec;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      used       <= '0;
      cnt        <= '0;
      pend       <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cnt        <= '0;
            pend       <= 1'b0;
            found      <= 1'b0;
            free_found <= 1'b0;
            unique case (opcode) inside
              srt_pkg::OP_SCAN_TICK, srt_pkg::OP_READING,
              srt_pkg::OP_OVR_SET, srt_pkg::OP_OVR_CLEAR: state <= S_SCAN;
              srt_pkg::OP_READ:                           state <= S_READ;
              default:                                    state <= S_FINISH;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_issue) begin
            cnt  <= cnt + CW'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (used[pidx] && rd_data.key == id_q && !found) begin
              found <= 1'b1;
            end
            if (!used[pidx] && !free_found) begin
              free_found <= 1'b1;
            end
            if (pidx == LAST_IDX) begin
              state <= S_FINISH;
            end
          end
        end
        S_READ: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (fin_go) begin
            if (fin_alloc) begin
              used[fin_idx] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_q    <= srt_pkg::opcode_t'(opcode);
      id_q    <= sensor_id;
      sel_q   <= entry_select;
      whole_q <= value_whole;
      fract_q <= (value_fract > srt_pkg::FRACT_MAX) ? srt_pkg::FRACT_MAX : value_fract;
      fpres_q <= fract_present;
    end
    if (scan_issue) begin
      pidx <= cnt[AW-1:0];
    end
    if (state == S_SCAN && pend) begin
      if (used[pidx] && rd_data.key == id_q && !found) begin
        hit_idx <= pidx;
        hit_rec <= rd_data;
      end
      if (!used[pidx] && !free_found) begin
        free_idx <= pidx;
      end
    end
    if (fin_go) begin
      status          <= fin_status;
      entry_index     <= fin_index;
      is_set          <= fin_report & fin_rec.valid;
      is_override     <= fin_report & fin_rec.forced;
      is_negative     <= fin_report & fin_rec.sign;
      whole_magnitude <= fin_report ? fin_rec.magnitude : 12'd0;
      fraction        <= fin_report ? fin_rec.hundredths : 7'd0;
      missed_scans    <= fin_report ? fin_rec.missed : 8'd0;
      rescan_request  <= fin_rescan;
    end
  end

endmodule

`default_nettype wire
